[hdl/deq_pkg.sv]
// Shared types for the double-ended queue core.
// Action codes, result status codes and control states. No dependencies.
package deq_pkg;

	typedef enum logic [2:0] {
		ACT_INS_FRONT  = 3'd0,
		ACT_INS_REAR   = 3'd1,
		ACT_DEL_FRONT  = 3'd2,
		ACT_DEL_REAR   = 3'd3,
		ACT_PEEK_FRONT = 3'd4,
		ACT_PEEK_REAR  = 3'd5,
		ACT_LIST       = 3'd6,
		ACT_NONE       = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LIST
	} state_t;

	localparam int unsigned DATA_W = 32;

endpackage

[hdl/double_ended_queue_core.sv]
// Top level of the double-ended queue core.
// Instantiates deq_ctrl and deq_mem; uses deq_pkg.
//
// Usage:
//   Command channel: an action/value transfer happens at a clock edge with
//   start high and busy low. Actions: insert front/rear, delete front/rear,
//   peek front/rear, list all; code 7 is ignored and gives no result.
//   Result channel: each result (status, data, last) is on the ports for one
//   cycle with strobe high. There is no back-pressure; the receiver must take
//   every result as it comes. last marks the final result of a command.
//   Latency / throughput:
//     insert, and any error result: result the cycle after the transfer;
//       busy stays low, so a new command may follow every cycle.
//     delete, peek: one memory read; result the cycle after the transfer,
//       busy high for that one cycle, so no new command is taken meanwhile.
//     list of N entries: N results back to back, one memory read per entry,
//       busy high while they are out.
//   Reset (arst_n low): queue empty, head at slot zero. The slot store is not
//   cleared; only written slots are ever read, so no clearing pass is needed.
//   Storage: DEPTH slots of 32 bits in one synchronous memory.
module double_ended_queue_core import deq_pkg::*; #(
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [2:0]               action,
	input  logic signed [DATA_W-1:0] value,
	output logic                     strobe,
	output logic [1:0]               status,
	output logic signed [DATA_W-1:0] data,
	output logic                     last
);

	// slot index and entry count widths; count must hold DEPTH itself
	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic                     mem_we;
	logic [IW-1:0]            mem_waddr;
	logic signed [DATA_W-1:0] mem_wdata;
	logic                     mem_re;
	logic [IW-1:0]            mem_raddr;
	logic signed [DATA_W-1:0] mem_rdata;

	// head/count bookkeeping, list walk and the result port
	deq_ctrl #(
		.DEPTH(DEPTH),
		.IW   (IW),
		.CW   (CW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.action   (action),
		.value    (value),
		.strobe   (strobe),
		.status   (status),
		.data     (data),
		.last     (last),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	// slot store: writes on insert, registered reads feed the result data
	deq_mem #(
		.DEPTH(DEPTH),
		.IW   (IW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

[hdl/deq_mem.sv]
// Slot store of the double-ended queue: one write port, one registered read port.
// Depends on deq_pkg for the data width.
module deq_mem import deq_pkg::*; #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned IW    = 5
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [IW-1:0]            waddr,
	input  logic signed [DATA_W-1:0] wdata,
	input  logic                     re,
	input  logic [IW-1:0]            raddr,
	output logic signed [DATA_W-1:0] rdata
);

	logic signed [DATA_W-1:0] slot_mem [DEPTH];
	logic signed [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			slot_mem[waddr] <= wdata;
		end
	end

	// registered read; rdata holds its last value while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= slot_mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/deq_ctrl.sv]
// Control for the double-ended queue: head/count bookkeeping, list walk, result port.
// Depends on deq_pkg; drives the deq_mem ports.
module deq_ctrl import deq_pkg::*; #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned IW    = 5,
	parameter int unsigned CW    = 6
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [2:0]               action,
	input  logic signed [DATA_W-1:0] value,
	output logic                     strobe,
	output logic [1:0]               status,
	output logic signed [DATA_W-1:0] data,
	output logic                     last,
	output logic                     mem_we,
	output logic [IW-1:0]            mem_waddr,
	output logic signed [DATA_W-1:0] mem_wdata,
	output logic                     mem_re,
	output logic [IW-1:0]            mem_raddr,
	input  logic signed [DATA_W-1:0] mem_rdata
);

	// (a + b) mod DEPTH, a < DEPTH, b <= DEPTH
	function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] s;
		s = (CW+1)'(a) + (CW+1)'(b);
		if (s >= (CW+1)'(DEPTH)) begin
			s = s - (CW+1)'(DEPTH);
		end
		return s[IW-1:0];
	endfunction

	state_t                   state_q, state_d;
	logic [IW-1:0]            head_q, head_d;
	logic [CW-1:0]            count_q, count_d;
	logic [IW-1:0]            ptr_q, ptr_d;
	logic [CW-1:0]            left_q, left_d;
	logic                     imm_vld_q, imm_vld_d;
	status_t                  imm_status_q, imm_status_d;
	logic signed [DATA_W-1:0] imm_data_q, imm_data_d;

	logic          full, empty;
	logic [IW-1:0] head_m1, rear_idx, tail_idx;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign head_m1  = (head_q == '0) ? IW'(DEPTH - 1) : head_q - IW'(1);
	assign tail_idx = wrap_add(head_q, count_q);
	assign rear_idx = wrap_add(head_q, count_q - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			count_q   <= '0;
			ptr_q     <= '0;
			left_q    <= '0;
			imm_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			count_q   <= count_d;
			ptr_q     <= ptr_d;
			left_q    <= left_d;
			imm_vld_q <= imm_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		imm_status_q <= imm_status_d;
		imm_data_q   <= imm_data_d;
	end

	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		count_d      = count_q;
		ptr_d        = ptr_q;
		left_d       = left_q;
		imm_vld_d    = 1'b0;
		imm_status_d = STAT_OK;
		imm_data_d   = '0;
		mem_we       = 1'b0;
		mem_waddr    = tail_idx;
		mem_wdata    = value;
		mem_re       = 1'b0;
		mem_raddr    = ptr_q;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (action_t'(action))
						ACT_INS_FRONT, ACT_INS_REAR: begin
							imm_vld_d = 1'b1;
							if (full) begin
								imm_status_d = STAT_FULL;
							end else begin
								mem_we     = 1'b1;
								imm_data_d = value;
								count_d    = count_q + CW'(1);
								if (action_t'(action) == ACT_INS_FRONT) begin
									mem_waddr = head_m1;
									head_d    = head_m1;
								end
							end
						end
						ACT_DEL_FRONT, ACT_DEL_REAR, ACT_PEEK_FRONT, ACT_PEEK_REAR: begin
							if (empty) begin
								imm_vld_d    = 1'b1;
								imm_status_d = STAT_EMPTY;
							end else begin
								mem_re  = 1'b1;
								state_d = ST_READ;
								if (action_t'(action) == ACT_DEL_FRONT ||
								    action_t'(action) == ACT_PEEK_FRONT) begin
									mem_raddr = head_q;
								end else begin
									mem_raddr = rear_idx;
								end
								if (action_t'(action) == ACT_DEL_FRONT) begin
									head_d  = wrap_add(head_q, CW'(1));
									count_d = count_q - CW'(1);
								end else if (action_t'(action) == ACT_DEL_REAR) begin
									count_d = count_q - CW'(1);
								end
							end
						end
						ACT_LIST: begin
							if (empty) begin
								imm_vld_d    = 1'b1;
								imm_status_d = STAT_EMPTY;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = head_q;
								ptr_d     = wrap_add(head_q, CW'(1));
								left_d    = count_q;
								state_d   = ST_LIST;
							end
						end
						ACT_NONE: begin
						end
					endcase
				end
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			ST_LIST: begin
				if (left_q == CW'(1)) begin
					state_d = ST_IDLE;
				end else begin
					mem_re = 1'b1;
					ptr_d  = wrap_add(ptr_q, CW'(1));
					left_d = left_q - CW'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// immediate results and memory-backed results never share a cycle
	assign busy   = (state_q != ST_IDLE);
	assign strobe = imm_vld_q | busy;
	assign status = imm_vld_q ? imm_status_q : STAT_OK;
	assign data   = imm_vld_q ? imm_data_q : mem_rdata;
	assign last   = imm_vld_q | (state_q == ST_READ) |
	                ((state_q == ST_LIST) && (left_q == CW'(1)));

endmodule

[hdl/deq_checker.sv]
// Port-level checks for double_ended_queue_core, attached by bind.
// Depends on deq_pkg.
module deq_checker import deq_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic [2:0]               action,
	input logic signed [DATA_W-1:0] value,
	input logic                     strobe,
	input logic [1:0]               status,
	input logic signed [DATA_W-1:0] data,
	input logic                     last
);

	// error results carry zero data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status != STAT_OK |-> data == '0)
		else $error("error result with nonzero data");

	// error results are always the single, final result of a command
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status != STAT_OK |-> last)
		else $error("error result without last");

	// insert, delete and peek answer with a single, final result in the cycle after the transfer
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && action <= 3'd5 |=> strobe && last)
		else $error("missing single result");

	// a successful insert echoes the inserted value
	a_ins_echo: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && action <= 3'd1 ##1 strobe && status == STAT_OK
		|-> data == $past(value))
		else $error("insert result does not echo value");

	// full status comes only from an insert, never from any other command
	a_full_src: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && action >= 3'd2 |=> status != STAT_FULL)
		else $error("full status from non-insert command");

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.action(action),
	.value (value),
	.strobe(strobe),
	.status(status),
	.data  (data),
	.last  (last)
);

[dv/tb_double_ended_queue_core.sv]
// Self-checking testbench for double_ended_queue_core.
// Drives action/value commands, predicts each result from a shadow copy of the
// deque, and checks every strobed result in order. Depends on deq_pkg and the core.
`timescale 1ns / 1ps

module tb_double_ended_queue_core;
	import deq_pkg::*;

	localparam int unsigned DEPTH = 32;

	// One command as the driver sends it. hold: wait for all results before sending.
	typedef struct {
		action_t                  act;
		logic signed [DATA_W-1:0] val;
		bit                       hold;
	} cmd_t;

	// One result as the core should produce it.
	typedef struct {
		status_t                  st;
		logic signed [DATA_W-1:0] dat;
		logic                     lst;
	} deq_result_t;

	logic                     clk    = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start  = 1'b0;
	logic [2:0]               action = ACT_NONE;
	logic signed [DATA_W-1:0] value  = '0;
	wire                      busy;
	wire                      strobe;
	wire  [1:0]               status;
	wire  signed [DATA_W-1:0] data;
	wire                      last;

	// Stimulus waiting to go out, and results owed by the core, oldest first.
	cmd_t        cmd_queue[$];
	deq_result_t due_results[$];

	// Shadow deque: circular store, front index and fill level.
	logic signed [DATA_W-1:0] shadow_slots [DEPTH];
	int unsigned              shadow_head  = 0;
	int unsigned              shadow_count = 0;

	int errors     = 0;
	bit took       = 1'b0;  // a transfer happened at the last rising edge
	int burst_left = 4;
	int gap_left   = 0;

	double_ended_queue_core #(
		.DEPTH(DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.action(action),
		.value (value),
		.strobe(strobe),
		.status(status),
		.data  (data),
		.last  (last)
	);

	always #2 clk = ~clk;

	function automatic deq_result_t mk_result(status_t st, logic signed [DATA_W-1:0] dat,
			logic lst);
		deq_result_t r;
		r.st  = st;
		r.dat = dat;
		r.lst = lst;
		return r;
	endfunction

	// Apply one accepted command to the shadow deque and queue the results it owes.
	task automatic predict_results(input cmd_t c);
		int unsigned idx;
		case (c.act)
			ACT_INS_FRONT, ACT_INS_REAR: begin
				if (shadow_count >= DEPTH) begin
					due_results.push_back(mk_result(STAT_FULL, '0, 1'b1));
				end else begin
					if (c.act == ACT_INS_FRONT) begin
						shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
						idx = shadow_head;
					end else begin
						idx = (shadow_head + shadow_count) % DEPTH;
					end
					shadow_slots[idx] = c.val;
					shadow_count++;
					due_results.push_back(mk_result(STAT_OK, c.val, 1'b1));
				end
			end
			ACT_DEL_FRONT, ACT_DEL_REAR, ACT_PEEK_FRONT, ACT_PEEK_REAR: begin
				if (shadow_count == 0) begin
					due_results.push_back(mk_result(STAT_EMPTY, '0, 1'b1));
				end else begin
					if (c.act == ACT_DEL_FRONT || c.act == ACT_PEEK_FRONT)
						idx = shadow_head;
					else
						idx = (shadow_head + shadow_count - 1) % DEPTH;
					due_results.push_back(mk_result(STAT_OK, shadow_slots[idx], 1'b1));
					if (c.act == ACT_DEL_FRONT) begin
						shadow_head = (shadow_head + 1) % DEPTH;
						shadow_count--;
					end else if (c.act == ACT_DEL_REAR) begin
						shadow_count--;
					end
				end
			end
			ACT_LIST: begin
				if (shadow_count == 0) begin
					due_results.push_back(mk_result(STAT_EMPTY, '0, 1'b1));
				end else begin
					// front to rear, last flag on the rear entry only
					for (int unsigned i = 0; i < shadow_count; i++)
						due_results.push_back(mk_result(STAT_OK,
							shadow_slots[(shadow_head + i) % DEPTH], i + 1 == shadow_count));
				end
			end
			default: ;  // unused code: no state change, no result
		endcase
	endtask

	task automatic add_cmd(action_t a, logic signed [DATA_W-1:0] v, bit h);
		cmd_t c;
		c.act  = a;
		c.val  = v;
		c.hold = h;
		cmd_queue.push_back(c);
	endtask

	// Random words half the time; otherwise the signed extremes, zero or all-ones.
	function automatic logic signed [DATA_W-1:0] rand_word();
		case ($urandom_range(0, 7))
			0:       return 32'h7fff_ffff;
			1:       return 32'h8000_0000;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// Driver: changes inputs on the falling edge. start holds while busy blocks
	// the transfer; otherwise the next command goes out unless in a gap or a hold.
	always @(negedge clk) begin : driver
		cmd_t c;
		if (arst_n && !(start && !took)) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (cmd_queue.size() == 0 ||
					(cmd_queue[0].hold && due_results.size() != 0)) begin
				start <= 1'b0;
			end else begin
				c = cmd_queue.pop_front();
				start  <= 1'b1;
				action <= c.act;
				value  <= c.val;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					// mix of short bursts and long stretches with no gap
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 8);
					gap_left = $urandom_range(1, 5);
				end
			end
		end
	end

	// Monitor: samples on the rising edge. Checks a strobed result first, then
	// predicts for a command transferred at the same edge, so order is kept.
	always @(posedge clk) begin : monitor
		deq_result_t r;
		cmd_t        c;
		if (!arst_n) begin
			took <= 1'b0;
		end else begin
			if (strobe) begin
				if (due_results.size() == 0) begin
					$error("result with nothing expected: status %0d data %0d last %0b",
						status, data, last);
					errors++;
				end else begin
					r = due_results.pop_front();
					if (status !== r.st) begin
						$error("status mismatch: expected %0d, actual %0d", r.st, status);
						errors++;
					end
					if (data !== r.dat) begin
						$error("data mismatch: expected %0d, actual %0d", r.dat, data);
						errors++;
					end
					if (last !== r.lst) begin
						$error("last mismatch: expected %0b, actual %0b", r.lst, last);
						errors++;
					end
				end
			end
			took <= start && !busy;
			if (start && !busy) begin
				c.act  = action_t'(action);
				c.val  = value;
				c.hold = 1'b0;
				predict_results(c);
			end
		end
	end

	initial begin : stimulus
		int         n;
		int         k;
		logic [2:0] code;
		action_t    a;

		// Directed: every error case on empty, the unused code, value extremes at
		// both ends, peeks, list, then back to empty.
		add_cmd(ACT_LIST, '0, 1'b0);
		add_cmd(ACT_DEL_FRONT, '0, 1'b0);
		add_cmd(ACT_DEL_REAR, '0, 1'b0);
		add_cmd(ACT_PEEK_FRONT, '0, 1'b0);
		add_cmd(ACT_PEEK_REAR, '0, 1'b0);
		add_cmd(ACT_NONE, $urandom, 1'b0);
		add_cmd(ACT_INS_FRONT, 32'h7fff_ffff, 1'b0);
		add_cmd(ACT_INS_REAR, 32'h8000_0000, 1'b0);
		add_cmd(ACT_INS_FRONT, '0, 1'b0);
		add_cmd(ACT_INS_REAR, '1, 1'b0);
		add_cmd(ACT_PEEK_FRONT, '0, 1'b0);
		add_cmd(ACT_PEEK_REAR, '0, 1'b0);
		add_cmd(ACT_LIST, '0, 1'b0);
		add_cmd(ACT_NONE, '1, 1'b0);
		add_cmd(ACT_DEL_FRONT, '0, 1'b0);
		add_cmd(ACT_DEL_REAR, '0, 1'b0);
		add_cmd(ACT_LIST, '0, 1'b0);
		add_cmd(ACT_DEL_REAR, '0, 1'b0);
		add_cmd(ACT_DEL_FRONT, '0, 1'b0);
		add_cmd(ACT_PEEK_REAR, '0, 1'b0);

		// Random part. Starts with a full fill/list/drain so full is always hit;
		// then a mix of fills, drains, short fill-and-empty runs and noise.
		n = 0;
		k = 5;
		while (n < 150) begin
			case (k)
				0, 1: begin  // noise: any code, unused one included
					for (int i = 0; i < 12; i++) begin
						code = $urandom_range(0, 7);
						add_cmd(action_t'(code), rand_word(), 1'b0);
					end
					n += 12;
				end
				2, 5: begin  // fill past full with random sides, then list
					for (int i = 0; i < DEPTH + 3; i++)
						add_cmd($urandom_range(0, 1) ? ACT_INS_REAR : ACT_INS_FRONT,
							rand_word(), i == 0);
					add_cmd(ACT_LIST, '0, 1'b0);
					n += DEPTH + 4;
					if (k == 5) begin
						k = 3;
						continue;
					end
				end
				3: begin  // drain toward empty, peeking now and then
					for (int i = 0; i < DEPTH + 3; i++) begin
						case ($urandom_range(0, 5))
							0:       a = ACT_PEEK_FRONT;
							1:       a = ACT_PEEK_REAR;
							2, 3:    a = ACT_DEL_FRONT;
							default: a = ACT_DEL_REAR;
						endcase
						add_cmd(a, rand_word(), 1'b0);
					end
					add_cmd(ACT_LIST, '0, 1'b0);
					n += DEPTH + 4;
				end
				default: begin  // a few inserts, list, a few deletes
					k = $urandom_range(1, 8);
					for (int i = 0; i < k; i++)
						add_cmd($urandom_range(0, 1) ? ACT_INS_REAR : ACT_INS_FRONT,
							rand_word(), i == 0 && $urandom_range(0, 3) == 0);
					add_cmd(ACT_LIST, '0, 1'b0);
					for (int i = 0; i < k; i++)
						add_cmd($urandom_range(0, 1) ? ACT_DEL_REAR : ACT_DEL_FRONT,
							'0, 1'b0);
					n += 2 * k + 1;
				end
			endcase
			k = $urandom_range(0, 4);
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmd_queue.size() != 0 || start)
			@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		// room for any result the core should not produce
		repeat (DEPTH + 8) @(posedge clk);

		if (errors == 0 && due_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

[files.f]
hdl/deq_pkg.sv
hdl/deq_mem.sv
hdl/deq_ctrl.sv
hdl/double_ended_queue_core.sv
hdl/deq_checker.sv
dv/tb_double_ended_queue_core.sv
